// File: sv/sfg_pkg.sv
// Shared types and constants for the spring force generator.
// No dependencies; the top level, spring_force_generator, imports this package.
package sfg_pkg;

    localparam int DATA_W          = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int K_W             = 31;
    localparam int REST_W          = 31;
    localparam int Q_W             = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE     = 3'd0,
        REG_K        = 3'd1,
        REG_REST     = 3'd2,
        REG_ANCHOR_X = 3'd3,
        REG_ANCHOR_Y = 3'd4,
        REG_ANCHOR_Z = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_SPRING   = 2'd0,
        MODE_ANCHORED = 2'd1,
        MODE_BUNGEE   = 2'd2
    } mode_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] pos_z;
        logic signed [DATA_W-1:0] partner_x;
        logic signed [DATA_W-1:0] partner_y;
        logic signed [DATA_W-1:0] partner_z;
    } sfg_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] force_x;
        logic signed [DATA_W-1:0] force_y;
        logic signed [DATA_W-1:0] force_z;
        logic                     applied;
    } sfg_out_t;

endpackage

// File: sv/sfg_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Carries an opaque tag and a valid bit alongside; no package dependencies.
module sfg_sqrt #(
    parameter int S_W   = 68,
    parameter int R_W   = 33,
    parameter int TAG_W = 105
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [S_W-1:0]   radicand,
    input  logic [TAG_W-1:0] tag_in,
    output logic             out_valid,
    output logic [R_W-1:0]   root,
    output logic [TAG_W-1:0] tag_out
);

    localparam int T_W = S_W + 2;

    logic             v_reg    [R_W];
    logic [T_W-1:0]   rem_reg  [R_W];
    logic [R_W-1:0]   root_reg [R_W];
    logic [TAG_W-1:0] tag_reg  [R_W];

    for (genvar k = 0; k < R_W; k++) begin : g_stage
        localparam int B = R_W - 1 - k;
        logic             v_in;
        logic [T_W-1:0]   rem_in;
        logic [R_W-1:0]   root_in;
        logic [TAG_W-1:0] t_in;
        logic [T_W-1:0]   trial;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = T_W'(radicand);
            assign root_in = '0;
            assign t_in    = tag_in;
        end else begin : g_later
            assign v_in    = v_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign t_in    = tag_reg[k-1];
        end

        // Growth of the square when this bit of the root is set.
        assign trial = (T_W'(root_in) << (B + 1)) + (T_W'(1) << (2 * B));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            tag_reg[k] <= t_in;
            if (rem_in >= trial)
            begin
                rem_reg[k]  <= rem_in - trial;
                root_reg[k] <= root_in | (R_W'(1) << B);
            end
            else
            begin
                rem_reg[k]  <= rem_in;
                root_reg[k] <= root_in;
            end
        end
    end

    assign out_valid = v_reg[R_W-1];
    assign root      = root_reg[R_W-1];
    assign tag_out   = tag_reg[R_W-1];

endmodule

// File: sv/sfg_div.sv
// Pipelined restoring divider: an overflow check stage, then one quotient bit per stage.
// Carries an opaque tag and a valid bit alongside; no package dependencies.
module sfg_div #(
    parameter int N_W   = 97,
    parameter int DEN_W = 49,
    parameter int Q_W   = 32,
    parameter int TAG_W = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [N_W-1:0]   num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] tag_in,
    output logic             out_valid,
    output logic [Q_W-1:0]   quot,
    output logic             ovf,
    output logic [TAG_W-1:0] tag_out
);

    localparam int W = ((N_W > DEN_W + Q_W) ? N_W : DEN_W + Q_W) + 1;

    logic             v_reg   [Q_W+1];
    logic [W-1:0]     rem_reg [Q_W+1];
    logic [Q_W-1:0]   q_reg   [Q_W+1];
    logic [DEN_W-1:0] den_reg [Q_W+1];
    logic [TAG_W-1:0] tag_reg [Q_W+1];
    logic             ovf_reg [Q_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
        end
    end

    // A quotient that does not fit in Q_W bits is flagged here and saturated later.
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= W'(num);
        q_reg[0]   <= '0;
        den_reg[0] <= den;
        tag_reg[0] <= tag_in;
        ovf_reg[0] <= W'(num) >= (W'(den) << Q_W);
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_stage
        localparam int J = Q_W - k;
        logic [W-1:0] trial;

        assign trial = W'(den_reg[k-1]) << J;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            den_reg[k] <= den_reg[k-1];
            tag_reg[k] <= tag_reg[k-1];
            ovf_reg[k] <= ovf_reg[k-1];
            if (rem_reg[k-1] >= trial)
            begin
                rem_reg[k] <= rem_reg[k-1] - trial;
                q_reg[k]   <= q_reg[k-1] | (Q_W'(1) << J);
            end
            else
            begin
                rem_reg[k] <= rem_reg[k-1];
                q_reg[k]   <= q_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[Q_W];
    assign quot      = q_reg[Q_W];
    assign ovf       = ovf_reg[Q_W];
    assign tag_out   = tag_reg[Q_W];

endmodule

// File: sv/spring_force_generator.sv
// Top level of the spring force generator: config registers, datapath stages, output.
// Depends on sfg_pkg, sfg_sqrt and sfg_div.

// The block takes one word per clock and never pushes back: busy is always low,
// so a word is accepted on every edge at which start is high. Each accepted word
// yields exactly one result word, shown for a single cycle with result_valid
// high. On its way it passes the square root pipeline, which resolves one bit
// of the spring length per stage, and the three parallel dividers, which
// resolve one bit of each force component per stage. Because the receiver
// cannot stall the block, it must take every result in the cycle it appears.
// Configuration writes take effect at once and must only be made while no word
// is in flight.
module spring_force_generator #(
    parameter int COORD_WIDTH = sfg_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = sfg_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  sfg_pkg::sfg_in_t              item,
    output logic                          result_valid,
    output sfg_pkg::sfg_out_t             result,
    input  logic                          cfg_write,
    input  logic [sfg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfg_pkg::DATA_W-1:0]    cfg_data
);

    import sfg_pkg::*;

    // Coordinates use at most 32 bits; the difference gains one bit.
    localparam int IN_BITS  = (COORD_WIDTH < DATA_W) ? COORD_WIDTH : DATA_W;
    localparam int D_W      = IN_BITS + 1;
    localparam int SQ_W     = 2 * D_W;
    localparam int S_W      = SQ_W + 2;
    localparam int L_W      = D_W;
    localparam int C_W      = (L_W > REST_W) ? L_W : REST_W;
    localparam int P_W      = C_W + K_W;
    localparam int LO_W     = 32;
    localparam int PH_W     = P_W - LO_W;
    localparam int PL_W     = LO_W + D_W;
    localparam int PHP_W    = PH_W + D_W;
    localparam int N_W      = P_W + D_W;
    localparam int DEN_W    = L_W + FRAC_BITS;
    localparam int TAG_W    = 3 * D_W + 6;
    localparam int DTAG_W   = 3;
    localparam int LATENCY  = 9 + L_W + Q_W;

    // ---------------------------------------------------------------------
    // Configuration registers.
    // ---------------------------------------------------------------------
    logic [1:0]        mode_reg;
    logic [K_W-1:0]    k_reg;
    logic [REST_W-1:0] rest_reg;
    logic [DATA_W-1:0] anchor_x_reg;
    logic [DATA_W-1:0] anchor_y_reg;
    logic [DATA_W-1:0] anchor_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_SPRING;
            k_reg        <= K_W'(65536);
            rest_reg     <= REST_W'(65536);
            anchor_x_reg <= '0;
            anchor_y_reg <= '0;
            anchor_z_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_MODE:     mode_reg     <= cfg_data[1:0];
                REG_K:        k_reg        <= cfg_data[K_W-1:0];
                REG_REST:     rest_reg     <= cfg_data[REST_W-1:0];
                REG_ANCHOR_X: anchor_x_reg <= cfg_data;
                REG_ANCHOR_Y: anchor_y_reg <= cfg_data;
                REG_ANCHOR_Z: anchor_z_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // The datapath never stalls, so a new word can be taken in every cycle.
    assign busy = 1'b0;

    // ---------------------------------------------------------------------
    // Stage 1: displacement per axis, split into magnitude, sign and nonzero flag.
    // ---------------------------------------------------------------------
    logic [DATA_W-1:0] pos_w [3];
    logic [DATA_W-1:0] oth_w [3];
    logic [D_W-1:0]    ad_c  [3];
    logic [2:0]        dneg_c;
    logic [2:0]        dnz_c;
    logic              anchored;

    assign anchored = (mode_reg == MODE_ANCHORED);
    assign pos_w[0] = item.pos_x;
    assign pos_w[1] = item.pos_y;
    assign pos_w[2] = item.pos_z;
    assign oth_w[0] = anchored ? anchor_x_reg : item.partner_x;
    assign oth_w[1] = anchored ? anchor_y_reg : item.partner_y;
    assign oth_w[2] = anchored ? anchor_z_reg : item.partner_z;

    always_comb
    begin
        logic [D_W-1:0] pa;
        logic [D_W-1:0] oa;
        logic [D_W-1:0] dv;
        for (int i = 0; i < 3; i++)
        begin
            pa        = {pos_w[i][IN_BITS-1], pos_w[i][IN_BITS-1:0]};
            oa        = {oth_w[i][IN_BITS-1], oth_w[i][IN_BITS-1:0]};
            dv        = pa - oa;
            dneg_c[i] = dv[D_W-1];
            dnz_c[i]  = |dv;
            ad_c[i]   = dv[D_W-1] ? (~dv + 1'b1) : dv;
        end
    end

    // Tag layout: {|d_z|, |d_y|, |d_x|, sign bits, nonzero bits}.
    logic             v1_reg;
    logic [TAG_W-1:0] tag1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        tag1_reg <= {ad_c[2], ad_c[1], ad_c[0], dneg_c, dnz_c};
    end

    // ---------------------------------------------------------------------
    // Stage 2: squares of the three magnitudes.
    // ---------------------------------------------------------------------
    logic             v2_reg;
    logic [SQ_W-1:0]  sq2_reg [3];
    logic [TAG_W-1:0] tag2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            sq2_reg[i] <= SQ_W'(tag1_reg[6 + i*D_W +: D_W]) * SQ_W'(tag1_reg[6 + i*D_W +: D_W]);
        end
        tag2_reg <= tag1_reg;
    end

    // ---------------------------------------------------------------------
    // Stage 3: squared length.
    // ---------------------------------------------------------------------
    logic             v3_reg;
    logic [S_W-1:0]   s3_reg;
    logic [TAG_W-1:0] tag3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_reg   <= S_W'(sq2_reg[0]) + S_W'(sq2_reg[1]) + S_W'(sq2_reg[2]);
        tag3_reg <= tag2_reg;
    end

    // ---------------------------------------------------------------------
    // Square root pipeline: the spring length L.
    // ---------------------------------------------------------------------
    logic             v_sq;
    logic [L_W-1:0]   len_sq;
    logic [TAG_W-1:0] tag_sq;

    sfg_sqrt #(
        .S_W   (S_W),
        .R_W   (L_W),
        .TAG_W (TAG_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .radicand  (s3_reg),
        .tag_in    (tag3_reg),
        .out_valid (v_sq),
        .root      (len_sq),
        .tag_out   (tag_sq)
    );

    // ---------------------------------------------------------------------
    // Stage 4: stretch |L - r| and the case flags. A slack bungee and a zero
    // length both force a zero output; only the slack bungee clears applied.
    // ---------------------------------------------------------------------
    logic [C_W-1:0] len_ext;
    logic [C_W-1:0] rest_ext;
    logic           slack_c;

    assign len_ext  = C_W'(len_sq);
    assign rest_ext = C_W'(rest_reg);
    assign slack_c  = (mode_reg == MODE_BUNGEE) && (len_ext <= rest_ext);

    logic             v4_reg;
    logic [C_W-1:0]   c4_reg;
    logic [L_W-1:0]   len4_reg;
    logic             fz4_reg;
    logic             app4_reg;
    logic             flip4_reg;
    logic [TAG_W-1:0] tag4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= v_sq;
        end
    end

    always_ff @(posedge clk)
    begin
        c4_reg    <= (len_ext >= rest_ext) ? (len_ext - rest_ext) : (rest_ext - len_ext);
        len4_reg  <= len_sq;
        fz4_reg   <= slack_c || (len_sq == '0);
        app4_reg  <= !slack_c;
        flip4_reg <= anchored && (len_ext < rest_ext);
        tag4_reg  <= tag_sq;
    end

    // ---------------------------------------------------------------------
    // Stage 5: c * k.
    // ---------------------------------------------------------------------
    logic             v5_reg;
    logic [P_W-1:0]   prod5_reg;
    logic [L_W-1:0]   len5_reg;
    logic             fz5_reg;
    logic             app5_reg;
    logic             flip5_reg;
    logic [TAG_W-1:0] tag5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod5_reg <= P_W'(c4_reg) * P_W'(k_reg);
        len5_reg  <= len4_reg;
        fz5_reg   <= fz4_reg;
        app5_reg  <= app4_reg;
        flip5_reg <= flip4_reg;
        tag5_reg  <= tag4_reg;
    end

    // ---------------------------------------------------------------------
    // Stage 6: partial products of (c*k) * |d_i|, and the output sign. In
    // anchored mode a compressed spring pushes outward, so the sign flips.
    // ---------------------------------------------------------------------
    logic             v6_reg;
    logic [PL_W-1:0]  pl6_reg [3];
    logic [PHP_W-1:0] ph6_reg [3];
    logic [L_W-1:0]   len6_reg;
    logic             fz6_reg;
    logic             app6_reg;
    logic [2:0]       neg6_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
        end
        else
        begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            pl6_reg[i] <= PL_W'(prod5_reg[LO_W-1:0]) * PL_W'(tag5_reg[6 + i*D_W +: D_W]);
            ph6_reg[i] <= PHP_W'(prod5_reg[P_W-1:LO_W]) * PHP_W'(tag5_reg[6 + i*D_W +: D_W]);
            neg6_reg[i] <= flip5_reg ? tag5_reg[3 + i] : (!tag5_reg[3 + i] && tag5_reg[i]);
        end
        len6_reg <= len5_reg;
        fz6_reg  <= fz5_reg;
        app6_reg <= app5_reg;
    end

    // ---------------------------------------------------------------------
    // Stage 7: full numerators.
    // ---------------------------------------------------------------------
    logic             v7_reg;
    logic [N_W-1:0]   num7_reg [3];
    logic [L_W-1:0]   len7_reg;
    logic             fz7_reg;
    logic             app7_reg;
    logic [2:0]       neg7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
        end
        else
        begin
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            num7_reg[i] <= (N_W'(ph6_reg[i]) << LO_W) + N_W'(pl6_reg[i]);
        end
        len7_reg <= len6_reg;
        fz7_reg  <= fz6_reg;
        app7_reg <= app6_reg;
        neg7_reg <= neg6_reg;
    end

    // ---------------------------------------------------------------------
    // Three dividers by L scaled to fixed point, one per axis.
    // ---------------------------------------------------------------------
    logic [DEN_W-1:0]  den7;
    logic              v_dv   [3];
    logic [Q_W-1:0]    q_dv   [3];
    logic              ovf_dv [3];
    logic [DTAG_W-1:0] tag_dv [3];

    assign den7 = DEN_W'(len7_reg) << FRAC_BITS;

    for (genvar i = 0; i < 3; i++) begin : g_div
        sfg_div #(
            .N_W   (N_W),
            .DEN_W (DEN_W),
            .Q_W   (Q_W),
            .TAG_W (DTAG_W)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (v7_reg),
            .num       (num7_reg[i]),
            .den       (den7),
            .tag_in    ({neg7_reg[i], fz7_reg, app7_reg}),
            .out_valid (v_dv[i]),
            .quot      (q_dv[i]),
            .ovf       (ovf_dv[i]),
            .tag_out   (tag_dv[i])
        );
    end

    // ---------------------------------------------------------------------
    // Final stage: saturate to the 32-bit range and apply the sign, or force zero.
    // ---------------------------------------------------------------------
    logic [DATA_W-1:0] force_c [3];

    always_comb
    begin
        logic [Q_W-1:0] lim;
        logic [Q_W-1:0] mag;
        for (int i = 0; i < 3; i++)
        begin
            lim = tag_dv[i][2] ? (Q_W'(1) << (Q_W - 1)) : ((Q_W'(1) << (Q_W - 1)) - 1'b1);
            mag = (ovf_dv[i] || (q_dv[i] > lim)) ? lim : q_dv[i];
            if (tag_dv[i][1])
            begin
                force_c[i] = '0;
            end
            else
            begin
                force_c[i] = tag_dv[i][2] ? DATA_W'(~mag + 1'b1) : DATA_W'(mag);
            end
        end
    end

    logic     result_valid_reg;
    sfg_out_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= v_dv[0];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.force_x <= force_c[0];
        result_reg.force_y <= force_c[1];
        result_reg.force_z <= force_c[2];
        result_reg.applied <= tag_dv[0][0];
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY result_valid)
        else $error("accepted word produced no result at the expected latency");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, LATENCY))
        else $error("result appeared without a matching accepted word");

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (v_dv[0] == v_dv[1]) && (v_dv[0] == v_dv[2]))
        else $error("divider lanes out of step");

    a_slack_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.applied) |->
        (result.force_x == '0) && (result.force_y == '0) && (result.force_z == '0))
        else $error("slack bungee produced a nonzero force");

endmodule
